>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the top-level design file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge once reset has been released.
`define VNU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset cycles included.
`define VNU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/vnu_pkg.sv
// ---------------------------------------------------------------------------
// vnu_pkg
// Widths, queue entry and control types for the vector norm unit.
// ---------------------------------------------------------------------------
package vnu_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;
  localparam int ACC_BITS    = 64;
  localparam int ACC_PAD     = ACC_BITS + 1 - SQ_BITS;
  localparam int ROOT_BITS   = ACC_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 3;
  localparam int STEP_BITS   = $clog2(ROOT_BITS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_IDX_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  // One finished vector waiting for its root.
  typedef struct packed {
    logic [ACC_BITS-1:0] sum;
    logic                sat;
  } vnu_entry_t;

  // Queue occupancy seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } vnu_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } vnu_root_state_t;

endpackage

>>> design/vector_euclidean_norm_unit.sv
// Throughput: one sample per cycle unless in_stall holds the input; the
//   bit-serial square root (32 iterations plus load and hand-off) takes a new vector only when done with the last.
// Reset: synchronous, active low; clears the sum, the saturation flag,
//   the queue and all valid flags.
// ---------------------------------------------------------------------------
// vector_euclidean_norm_unit
// Streaming L2 norm: saturating sum of squares, then floor integer root.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_euclidean_norm_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [vnu_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [vnu_pkg::ROOT_BITS-1:0]          out_norm,
  output logic                                   out_saturated
);
  import vnu_pkg::*;

  // Front to queue: one entry per completed vector.
  logic       q_push;
  vnu_entry_t q_entry;
  // Queue to back: head of queue and occupancy.
  logic       q_pop;
  vnu_entry_t q_head;
  vnu_qstat_t qstat;

  // Front: square each beat, accumulate with saturation, push on last.
  // It keeps taking samples while the root unit works on an earlier
  // vector, and holds only when a vector end finds the queue full.
  vnu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_last   (in_last),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // Queue: decouple the accumulator from the slow root unit.
  vnu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  // Back: restoring square root, one root bit per cycle, then drive the
  // result beat from its own register; stalls on the output side reach the
  // front only through a full queue.
  vnu_root u_root (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .head          (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_norm      (out_norm),
    .out_saturated (out_saturated)
  );

  // Never push into a full queue without a pop in the same cycle.
  `VNU_ASSERT(a_no_overflow, (q_push && !q_pop) |-> !qstat.full, "push into full queue")
  // Never pop an empty queue.
  `VNU_ASSERT(a_no_underflow, q_pop |-> !qstat.empty, "pop from empty queue")
  // No result beat straight after reset.
  `VNU_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

>>> design/vnu_front.sv
// ---------------------------------------------------------------------------
// vnu_front
// Squares each sample, adds it to the saturating sum of squares and queues the sum at each vector end.
// ---------------------------------------------------------------------------
module vnu_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vnu_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 in_last,
  input  vnu_pkg::vnu_qstat_t                  qstat,
  output logic                                 q_push,
  output vnu_pkg::vnu_entry_t                  q_entry
);
  import vnu_pkg::*;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_BITS-1:0]     sq_r;
  logic                   sq_vld_r;
  logic                   sq_last_r;
  logic [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic                   flag_r, flag_nxt;
  logic [ACC_BITS:0]      sum_ext;
  logic [ACC_BITS-1:0]    sum_sat;
  logic                   flag_new;
  logic                   adv;
  logic                   in_acc;

  // Magnitude of the two's complement sample; the most negative code wraps
  // to 2^(SAMPLE_BITS-1) which still fits as unsigned.
  assign mag = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;

  // Advance the squared sample unless a vector end finds the queue full.
  assign adv      = sq_vld_r && !(sq_last_r && qstat.full);
  assign in_stall = sq_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (in_acc) begin
      sq_vld_r <= 1'b1;
    end else if (adv) begin
      sq_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_r      <= SQ_BITS'(mag) * SQ_BITS'(mag);
      sq_last_r <= in_last;
    end
  end

  assign sum_ext  = {1'b0, acc_r} + {{ACC_PAD{1'b0}}, sq_r};
  assign sum_sat  = sum_ext[ACC_BITS] ? {ACC_BITS{1'b1}} : sum_ext[ACC_BITS-1:0];
  assign flag_new = flag_r | sum_ext[ACC_BITS];

  assign q_push      = adv && sq_last_r;
  assign q_entry.sum = sum_sat;
  assign q_entry.sat = flag_new;

  always_comb begin
    acc_nxt  = acc_r;
    flag_nxt = flag_r;
    if (adv) begin
      if (sq_last_r) begin
        acc_nxt  = '0;
        flag_nxt = 1'b0;
      end else begin
        acc_nxt  = sum_sat;
        flag_nxt = flag_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

>>> design/vnu_queue.sv
// ---------------------------------------------------------------------------
// vnu_queue
// Short FIFO of finished sums between the accumulator and the root unit.
// ---------------------------------------------------------------------------
module vnu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vnu_pkg::vnu_entry_t push_entry,
  input  logic                pop,
  output vnu_pkg::vnu_entry_t head,
  output vnu_pkg::vnu_qstat_t qstat
);
  import vnu_pkg::*;

  vnu_entry_t            slot_r [Q_DEPTH];
  logic [Q_IDX_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> design/vnu_root.sv
// ---------------------------------------------------------------------------
// vnu_root
// Digit-by-digit integer square root, one root bit per cycle, with the
// result beat held in an output register.
// ---------------------------------------------------------------------------
module vnu_root (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vnu_pkg::vnu_qstat_t            qstat,
  input  vnu_pkg::vnu_entry_t            head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vnu_pkg::ROOT_BITS-1:0]  out_norm,
  output logic                           out_saturated
);
  import vnu_pkg::*;

  vnu_root_state_t       state_r, state_nxt;
  logic [ACC_BITS-1:0]   rad_r;
  logic [REM_BITS-1:0]   rem_r;
  logic [ROOT_BITS-1:0]  root_r;
  logic [STEP_BITS-1:0]  step_r;
  logic                  sat_r;
  logic                  out_vld_r;
  logic [REM_BITS-1:0]   rem_sh, trial;
  logic                  ge;
  logic                  load_out;

  // Bring down the next two radicand bits and try appending a one.
  assign rem_sh = {rem_r[REM_BITS-3:0], rad_r[ACC_BITS-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign q_pop    = (state_r == ST_IDLE) && !qstat.empty;
  assign load_out = (state_r == ST_HOLD) && (!out_vld_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!qstat.empty) state_nxt = ST_RUN;
      ST_RUN:  if (step_r == '0) state_nxt = ST_HOLD;
      ST_HOLD: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rad_r  <= head.sum;
      sat_r  <= head.sat;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= STEP_BITS'(ROOT_BITS - 1);
    end else if (state_r == ST_RUN) begin
      rad_r  <= {rad_r[ACC_BITS-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_BITS-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_norm      <= root_r;
      out_saturated <= sat_r;
    end
  end

  assign out_valid = out_vld_r;

endmodule
